// File: hw/rtl/tkr_pkg.sv
// ----------------------------------------------------------------------------
// tkr_pkg: shared definitions of the top-K resident size tracker
// Sizes, item kind codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package tkr_pkg;

  localparam int TOP_K   = 20;
  localparam int IDX_W   = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int KIND_W  = 2;
  localparam int PID_W   = 22;
  localparam int PAGES_W = 32;
  localparam int COUNT_W = 16;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOP_K - 1);

  localparam logic [KIND_W-1:0] KIND_OFFER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DUMP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Commands from the controller to the datapath, valid for one cycle.
  typedef struct packed {
    logic             offer;
    logic             clear;
    logic             load_out;
    logic [IDX_W-1:0] read_idx;
  } cmd_t;

endpackage

// File: hw/rtl/tkr_datapath.sv
// ----------------------------------------------------------------------------
// tkr_datapath: sorted slot chain, process counter and output register
// Every slot compares its resident size with the newcomer in parallel, so an
// insertion and its shift are written into the slot registers together.
// ----------------------------------------------------------------------------
module tkr_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tkr_pkg::cmd_t                cmd_i,
  input  logic [tkr_pkg::PID_W-1:0]    process_id_i,
  input  logic                         has_memory_i,
  input  logic [tkr_pkg::PAGES_W-1:0]  virtual_pages_i,
  input  logic [tkr_pkg::PAGES_W-1:0]  resident_pages_i,
  output logic                         slot_valid_o,
  output logic [tkr_pkg::PID_W-1:0]    slot_pid_o,
  output logic [tkr_pkg::PAGES_W-1:0]  slot_virtual_o,
  output logic [tkr_pkg::PAGES_W-1:0]  slot_resident_o,
  output logic [tkr_pkg::COUNT_W-1:0]  seen_count_o,
  output logic                         last_slot_o
);

  typedef struct packed {
    logic [tkr_pkg::PID_W-1:0]   pid;
    logic [tkr_pkg::PAGES_W-1:0] virt;
    logic [tkr_pkg::PAGES_W-1:0] res;
  } entry_t;

  logic   [tkr_pkg::TOP_K-1:0]   valid_q, valid_d;
  entry_t                        entry_q [tkr_pkg::TOP_K];
  entry_t                        entry_d [tkr_pkg::TOP_K];
  logic   [tkr_pkg::TOP_K-1:0]   take;
  logic   [tkr_pkg::TOP_K-1:0]   prev_take;
  logic   [tkr_pkg::COUNT_W-1:0] count_q, count_d;
  entry_t                        new_entry;
  entry_t                        rd_entry;
  logic                          rd_valid;
  logic                          insert;

  assign new_entry = '{pid: process_id_i, virt: virtual_pages_i, res: resident_pages_i};
  assign insert    = cmd_i.offer & has_memory_i;

  // The occupied slots form a prefix sorted from largest to smallest, so the
  // take flags are monotonic: the first raised flag marks the insertion slot
  // and every slot behind it takes over its upper neighbor.
  always_comb begin
    for (int i = 0; i < tkr_pkg::TOP_K; i++) begin
      take[i] = ~valid_q[i] | (resident_pages_i >= entry_q[i].res);
    end
    prev_take[0] = 1'b0;
    for (int i = 1; i < tkr_pkg::TOP_K; i++) begin
      prev_take[i] = take[i-1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < tkr_pkg::TOP_K; i++) begin
      entry_d[i] = entry_q[i];
    end
    if (cmd_i.clear) begin
      valid_d = '0;
    end else if (insert) begin
      if (take[0]) begin
        valid_d[0] = 1'b1;
        entry_d[0] = new_entry;
      end
      for (int i = 1; i < tkr_pkg::TOP_K; i++) begin
        if (prev_take[i]) begin
          valid_d[i] = valid_q[i-1];
          entry_d[i] = entry_q[i-1];
        end else if (take[i]) begin
          valid_d[i] = 1'b1;
          entry_d[i] = new_entry;
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.offer && (count_q != {tkr_pkg::COUNT_W{1'b1}})) begin
      count_d = count_q + tkr_pkg::COUNT_W'(1);
    end
  end

  assign rd_valid = valid_q[cmd_i.read_idx];
  assign rd_entry = entry_q[cmd_i.read_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < tkr_pkg::TOP_K; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  // Empty slots report zero payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      slot_valid_o    <= rd_valid;
      slot_pid_o      <= rd_valid ? rd_entry.pid  : '0;
      slot_virtual_o  <= rd_valid ? rd_entry.virt : '0;
      slot_resident_o <= rd_valid ? rd_entry.res  : '0;
      seen_count_o    <= count_q;
      last_slot_o     <= (cmd_i.read_idx == tkr_pkg::LAST_IDX);
    end
  end

endmodule

// File: hw/rtl/tkr_ctrl.sv
// ----------------------------------------------------------------------------
// tkr_ctrl: item handshake and dump sequencer
// Decodes accepted items into datapath commands and walks the slots on a dump.
// ----------------------------------------------------------------------------
module tkr_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tkr_pkg::KIND_W-1:0] kind_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tkr_pkg::cmd_t              cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e                    state_q, state_d;
  logic [tkr_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  logic                      accept;
  logic                      out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    out_valid_d    = out_valid_q & ~out_ready_i;
    cmd_o.offer    = 1'b0;
    cmd_o.clear    = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.read_idx = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            tkr_pkg::KIND_OFFER: cmd_o.offer = 1'b1;
            tkr_pkg::KIND_DUMP:  state_d = ST_DUMP;
            tkr_pkg::KIND_CLEAR: cmd_o.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          if (idx_q == tkr_pkg::LAST_IDX) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + tkr_pkg::IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= tkr_pkg::LAST_IDX)
    else $error("slot index beyond the last slot");

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (idx_q == '0))
    else $error("slot index not rewound while idle");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_out && (idx_q == tkr_pkg::LAST_IDX)) |=> (state_q == ST_IDLE))
    else $error("dump did not end after the last slot");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && !$past(cmd_o.load_out)))
    else $error("stalled result item dropped or overwritten");
`endif

endmodule

// File: hw/rtl/top_k_rss_tracker_unit.sv
// ----------------------------------------------------------------------------
// top_k_rss_tracker_unit: top-K largest resident size process list
// Keeps the TOP_K offered processes with memory that have the largest resident size, sorted.
// ----------------------------------------------------------------------------
// Offer and clear items produce no result, so they can be accepted back to
// back. A dump item produces TOP_K result items, one per cycle while the
// output is not stalled, read out through a single slot index walked by the
// controller; no input item is accepted until the last slot of the dump has
// entered the output register. A result item may still wait at the output
// while the next input item is taken.
module top_k_rss_tracker_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tkr_pkg::KIND_W-1:0]   kind_i,
  input  logic [tkr_pkg::PID_W-1:0]    process_id_i,
  input  logic                         has_memory_i,
  input  logic [tkr_pkg::PAGES_W-1:0]  virtual_pages_i,
  input  logic [tkr_pkg::PAGES_W-1:0]  resident_pages_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         slot_valid_o,
  output logic [tkr_pkg::PID_W-1:0]    slot_pid_o,
  output logic [tkr_pkg::PAGES_W-1:0]  slot_virtual_o,
  output logic [tkr_pkg::PAGES_W-1:0]  slot_resident_o,
  output logic [tkr_pkg::COUNT_W-1:0]  seen_count_o,
  output logic                         last_slot_o
);

  tkr_pkg::cmd_t cmd;

  tkr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tkr_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .process_id_i     (process_id_i),
    .has_memory_i     (has_memory_i),
    .virtual_pages_i  (virtual_pages_i),
    .resident_pages_i (resident_pages_i),
    .slot_valid_o     (slot_valid_o),
    .slot_pid_o       (slot_pid_o),
    .slot_virtual_o   (slot_virtual_o),
    .slot_resident_o  (slot_resident_o),
    .seen_count_o     (seen_count_o),
    .last_slot_o      (last_slot_o)
  );

endmodule
